@@ hdl/dbsm_pkg.sv @@
// Shared types, codes and sizes for the DFA byte-stream matcher.
`default_nettype none

package dbsm_pkg;

  localparam int DEFAULT_STATE_COUNT   = 256;
  localparam int DEFAULT_POSITION_BITS = 32;

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int FILL_BITS  = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] OP_WR_TRANS  = 2'd0;
  localparam logic [1:0] OP_WR_ACCEPT = 2'd1;
  localparam logic [1:0] OP_DATA      = 2'd2;
  localparam logic [1:0] OP_END       = 2'd3;

  localparam logic [1:0] KIND_MATCH   = 2'd0;
  localparam logic [1:0] KIND_VERDICT = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] state_index;
    logic [7:0] symbol;
    logic [7:0] next_state;
    logic       next_valid;
    logic       accept_flag;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] match_start;
    logic [31:0] match_length;
    logic [31:0] match_id;
    logic        matched;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic      valid0;
    logic      valid1;
    out_item_t item0;
    out_item_t item1;
  } res_push_t;

  typedef struct packed {
    logic                 nonempty;
    logic [FILL_BITS-1:0] fill;
  } fifo_stat_t;

endpackage

`default_nettype wire

@@ hdl/dbsm_tables.sv @@
// Transition and accepting-mark memories with the post-reset clearing sweep.
`default_nettype none

module dbsm_tables import dbsm_pkg::*; #(
  parameter int STATE_COUNT = DEFAULT_STATE_COUNT
) (
  input  wire                                                   clk,
  input  wire                                                   rst_n,
  input  wire                                                   t_we,
  input  wire  [$clog2((STATE_COUNT > 256) ? 256 : STATE_COUNT)+7:0] t_waddr,
  input  wire  [$clog2((STATE_COUNT > 256) ? 256 : STATE_COUNT):0]   t_wdata,
  input  wire                                                   a_we,
  input  wire  [$clog2((STATE_COUNT > 256) ? 256 : STATE_COUNT)-1:0] a_waddr,
  input  wire                                                   a_wdata,
  input  wire  [$clog2((STATE_COUNT > 256) ? 256 : STATE_COUNT)+7:0] ta_raddr,
  input  wire  [$clog2((STATE_COUNT > 256) ? 256 : STATE_COUNT)+7:0] tb_raddr,
  input  wire  [$clog2((STATE_COUNT > 256) ? 256 : STATE_COUNT)-1:0] a_raddr,
  output logic [$clog2((STATE_COUNT > 256) ? 256 : STATE_COUNT):0]   ta_rdata,
  output logic [$clog2((STATE_COUNT > 256) ? 256 : STATE_COUNT):0]   tb_rdata,
  output logic                                                  a_rdata,
  output logic                                                  clr_busy
);

  localparam int ROWS  = (STATE_COUNT > 256) ? 256 : STATE_COUNT;
  localparam int SB    = $clog2(ROWS);
  localparam int TAW   = SB + 8;
  localparam int DEPTH = ROWS * 256;
  localparam logic [TAW-1:0] CLR_LAST = TAW'(DEPTH - 1);

  logic [SB:0]    tmem [DEPTH];
  logic           amem [ROWS];
  logic [SB:0]    ta_rd_r;
  logic [SB:0]    tb_rd_r;
  logic           a_rd_r;
  logic           clr_busy_r;
  logic [TAW-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == CLR_LAST) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_idx_r <= clr_idx_r + TAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      tmem[clr_idx_r]          <= '0;
      amem[clr_idx_r[TAW-1:8]] <= 1'b0;
    end else begin
      if (t_we) begin
        tmem[t_waddr] <= t_wdata;
      end
      if (a_we) begin
        amem[a_waddr] <= a_wdata;
      end
    end
    ta_rd_r <= tmem[ta_raddr];
    tb_rd_r <= tmem[tb_raddr];
    a_rd_r  <= amem[a_raddr];
  end

  assign ta_rdata = ta_rd_r;
  assign tb_rdata = tb_rd_r;
  assign a_rdata  = a_rd_r;
  assign clr_busy = clr_busy_r;

endmodule

`default_nettype wire

@@ hdl/dbsm_result_fifo.sv @@
// Result queue taking up to two beats per cycle and giving one.
`default_nettype none

module dbsm_result_fifo import dbsm_pkg::*; (
  input  wire            clk,
  input  wire            rst_n,
  input  wire res_push_t push,
  input  wire            pop,
  output out_item_t      head,
  output fifo_stat_t     stat
);

  out_item_t            qmem [FIFO_DEPTH];
  logic [PTR_BITS-1:0]  wptr_r;
  logic [PTR_BITS-1:0]  wptr_nxt;
  logic [PTR_BITS-1:0]  rptr_r;
  logic [FILL_BITS-1:0] fill_r;

  assign wptr_nxt = wptr_r + PTR_BITS'(1);

  always_ff @(posedge clk) begin
    if (push.valid0) begin
      qmem[wptr_r] <= push.item0;
    end
    if (push.valid1) begin
      qmem[wptr_nxt] <= push.item1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_r + PTR_BITS'(push.valid0) + PTR_BITS'(push.valid1);
      if (pop) begin
        rptr_r <= rptr_r + PTR_BITS'(1);
      end
      fill_r <= fill_r + FILL_BITS'(push.valid0) + FILL_BITS'(push.valid1)
              - FILL_BITS'(pop);
    end
  end

  assign head          = qmem[rptr_r];
  assign stat.nonempty = (fill_r != '0);
  assign stat.fill     = fill_r;

endmodule

`default_nettype wire

@@ hdl/dfa_byte_stream_matcher.sv @@
// Top level of the DFA byte-stream matcher: lookup pipeline, match tracking and result queue.
//
// Takes one item per cycle while in_stall is low. A data byte reads its transition in the
// cycle it is accepted, using the state the byte ahead of it resolves in that same cycle, so
// the registered table read forms the loop that sets the byte rate; a dead transition is
// resolved in the same pass because the entry-state row is read on a second port. Table
// writes produce nothing. Results pass the lookup stage, the accept stage and the result
// queue before they reach out_valid; the input stalls when the 8-beat result queue lacks
// room for two beats from each of up to three items in flight. After reset the tables are
// cleared by a sweep over all min(STATE_COUNT,256)*256 transition entries (65536 by default)
// during which in_stall stays high; configuration writes are taken at any time.
`default_nettype none

module dfa_byte_stream_matcher import dbsm_pkg::*; #(
  parameter int STATE_COUNT   = DEFAULT_STATE_COUNT,
  parameter int POSITION_BITS = DEFAULT_POSITION_BITS
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire           out_stall,
  output out_item_t     out_data,
  input  wire           cfg_valid,
  output logic          cfg_ready,
  input  wire           cfg_data
);

  localparam int ROWS = (STATE_COUNT > 256) ? 256 : STATE_COUNT;
  localparam int SB   = $clog2(ROWS);
  localparam int TAW  = SB + 8;
  localparam int PB   = POSITION_BITS;
  localparam int RW   = FILL_BITS + 2;
  localparam logic [PB-1:0] POS_MAX = '1;
  localparam logic [31:0]   ID_MAX  = '1;

  function automatic logic [31:0] sat32(input logic [64:0] v);
    return (|v[64:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  logic           mode_r;

  logic           in_acc;
  logic           si_ok;
  logic           ns_ok;
  logic           data_in;
  logic           eos_in;
  logic           t_we;
  logic           a_we;
  logic [TAW-1:0] t_waddr;
  logic [SB:0]    t_wdata;
  logic [TAW-1:0] ta_raddr;
  logic [TAW-1:0] tb_raddr;
  logic [SB-1:0]  a_raddr;
  logic [SB:0]    ta_rdata;
  logic [SB:0]    tb_rdata;
  logic           a_rdata;
  logic           clr_busy;

  logic           b_v_r;
  logic           b_eos_r;
  logic [SB-1:0]  cur_r;
  logic [SB-1:0]  cur_nxt;
  logic           inside_r;
  logic           inside_nxt;
  logic           failed_r;
  logic           failed_nxt;
  logic [PB-1:0]  begin_r;
  logic [PB-1:0]  begin_nxt;
  logic [PB-1:0]  pos_r;
  logic [PB-1:0]  pos_nxt;
  logic           b_flush;
  logic           b_start;
  logic           b_adv;

  logic           c_v_r;
  logic           c_eos_r;
  logic           c_flush_r;
  logic           c_start_r;
  logic           c_adv_r;
  logic           c_failed_r;
  logic [PB-1:0]  c_begin_r;
  logic [PB-1:0]  c_pos_r;
  logic           seen_r;
  logic           seen_nxt;
  logic [PB-1:0]  lpos_r;
  logic [PB-1:0]  lpos_nxt;
  logic [31:0]    id_r;
  logic [31:0]    id_nxt;
  logic [31:0]    id_inc;
  logic [PB:0]    match_len;
  logic           emit_m;
  out_item_t      match_item;
  out_item_t      end_item;
  out_item_t      verdict_item;
  res_push_t      push;

  logic           pop;
  out_item_t      head;
  fifo_stat_t     fstat;
  logic [RW-1:0]  reserve;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  // acceptance and table writes
  assign reserve = RW'(fstat.fill) + RW'({b_v_r, 1'b0}) + RW'({c_v_r, 1'b0}) + RW'(2'd2);
  assign in_stall = clr_busy || (reserve > RW'(FIFO_DEPTH));
  assign in_acc   = in_valid && !in_stall;

  assign si_ok   = (32'(in_data.state_index) < STATE_COUNT);
  assign ns_ok   = (32'(in_data.next_state) < STATE_COUNT);
  assign data_in = (in_data.op == OP_DATA) && (in_data.data_byte != 8'd0);
  assign eos_in  = (in_data.op == OP_END) ||
                   ((in_data.op == OP_DATA) && (in_data.data_byte == 8'd0));

  assign t_we    = in_acc && (in_data.op == OP_WR_TRANS) && si_ok;
  assign t_waddr = {in_data.state_index[SB-1:0], in_data.symbol};
  assign t_wdata = {in_data.next_valid && ns_ok, in_data.next_state[SB-1:0]};
  assign a_we    = in_acc && (in_data.op == OP_WR_ACCEPT) && si_ok;

  assign ta_raddr = {cur_nxt, in_data.data_byte};
  assign tb_raddr = {SB'(0), in_data.data_byte};
  assign a_raddr  = b_eos_r ? cur_r : cur_nxt;

  dbsm_tables #(
    .STATE_COUNT(STATE_COUNT)
  ) u_tables (
    .clk      (clk),
    .rst_n    (rst_n),
    .t_we     (t_we),
    .t_waddr  (t_waddr),
    .t_wdata  (t_wdata),
    .a_we     (a_we),
    .a_waddr  (in_data.state_index[SB-1:0]),
    .a_wdata  (in_data.accept_flag),
    .ta_raddr (ta_raddr),
    .tb_raddr (tb_raddr),
    .a_raddr  (a_raddr),
    .ta_rdata (ta_rdata),
    .tb_rdata (tb_rdata),
    .a_rdata  (a_rdata),
    .clr_busy (clr_busy)
  );

  // lookup stage: resolve the next state, forwarded to the following byte's read
  always_comb begin
    cur_nxt    = cur_r;
    inside_nxt = inside_r;
    failed_nxt = failed_r;
    begin_nxt  = begin_r;
    pos_nxt    = pos_r;
    b_flush    = 1'b0;
    b_start    = 1'b0;
    b_adv      = 1'b0;
    if (b_v_r) begin
      if (b_eos_r) begin
        b_flush    = inside_r && !mode_r;
        cur_nxt    = '0;
        inside_nxt = 1'b0;
        failed_nxt = 1'b0;
        begin_nxt  = '0;
        pos_nxt    = '0;
      end else begin
        if (mode_r) begin
          if (!failed_r) begin
            if (ta_rdata[SB]) begin
              cur_nxt = ta_rdata[SB-1:0];
            end else begin
              failed_nxt = 1'b1;
            end
          end
        end else if (inside_r && ta_rdata[SB]) begin
          cur_nxt = ta_rdata[SB-1:0];
          b_adv   = 1'b1;
        end else begin
          b_flush    = inside_r;
          inside_nxt = 1'b0;
          if (tb_rdata[SB]) begin
            b_start    = 1'b1;
            inside_nxt = 1'b1;
            begin_nxt  = pos_r;
            cur_nxt    = tb_rdata[SB-1:0];
          end
        end
        pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + PB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r    <= 1'b0;
      c_v_r    <= 1'b0;
      cur_r    <= '0;
      inside_r <= 1'b0;
      failed_r <= 1'b0;
      begin_r  <= '0;
      pos_r    <= '0;
      seen_r   <= 1'b0;
      lpos_r   <= '0;
      id_r     <= '0;
    end else begin
      b_v_r    <= in_acc && (data_in || eos_in);
      c_v_r    <= b_v_r;
      cur_r    <= cur_nxt;
      inside_r <= inside_nxt;
      failed_r <= failed_nxt;
      begin_r  <= begin_nxt;
      pos_r    <= pos_nxt;
      seen_r   <= seen_nxt;
      lpos_r   <= lpos_nxt;
      id_r     <= id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_eos_r    <= eos_in;
    c_eos_r    <= b_eos_r;
    c_flush_r  <= b_flush;
    c_start_r  <= b_start;
    c_adv_r    <= b_adv;
    c_failed_r <= failed_r;
    c_begin_r  <= begin_r;
    c_pos_r    <= pos_r;
  end

  // accept stage: longest accepting prefix, match numbering and result beats
  assign match_len = {1'b0, lpos_r} - {1'b0, c_begin_r} + (PB+1)'(1);
  assign id_inc    = (id_r == ID_MAX) ? id_r : id_r + 32'd1;
  assign emit_m    = c_flush_r && seen_r;

  always_comb begin
    match_item.kind         = KIND_MATCH;
    match_item.match_start  = sat32(65'(c_begin_r));
    match_item.match_length = sat32(65'(match_len));
    match_item.match_id     = id_r;
    match_item.matched      = 1'b0;
    match_item.last         = !c_eos_r;

    end_item.kind           = KIND_END;
    end_item.match_start    = sat32(65'(c_pos_r));
    end_item.match_length   = 32'd0;
    end_item.match_id       = emit_m ? id_inc : id_r;
    end_item.matched        = 1'b0;
    end_item.last           = 1'b1;

    verdict_item.kind         = KIND_VERDICT;
    verdict_item.match_start  = 32'd0;
    verdict_item.match_length = sat32(65'(c_pos_r));
    verdict_item.match_id     = 32'd0;
    verdict_item.matched      = !c_failed_r && a_rdata;
    verdict_item.last         = 1'b1;
  end

  always_comb begin
    seen_nxt    = seen_r;
    lpos_nxt    = lpos_r;
    id_nxt      = id_r;
    push.valid0 = 1'b0;
    push.valid1 = 1'b0;
    push.item0  = match_item;
    push.item1  = end_item;
    if (c_v_r) begin
      if (!c_eos_r) begin
        if (emit_m) begin
          push.valid0 = 1'b1;
          id_nxt      = id_inc;
        end
        if (c_start_r) begin
          seen_nxt = a_rdata;
          lpos_nxt = c_pos_r;
        end else if (c_adv_r && a_rdata) begin
          seen_nxt = 1'b1;
          lpos_nxt = c_pos_r;
        end
      end else begin
        push.valid0 = 1'b1;
        if (mode_r) begin
          push.item0 = verdict_item;
        end else if (emit_m) begin
          push.valid1 = 1'b1;
        end else begin
          push.item0 = end_item;
        end
        seen_nxt = 1'b0;
        lpos_nxt = '0;
        id_nxt   = '0;
      end
    end
  end

  assign pop = out_valid && !out_stall;

  dbsm_result_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (fstat)
  );

  assign out_valid = fstat.nonempty;
  assign out_data  = head;

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fstat.fill <= FILL_BITS'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
    c_v_r |-> $past(b_v_r))
    else $error("accept stage valid without a preceding lookup");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy) |-> (!b_v_r && !c_v_r && !fstat.nonempty))
    else $error("work in flight while the tables were clearing");

endmodule

`default_nettype wire
